FILE: design/calu_pkg.sv
`timescale 1ns / 1ps

package calu_pkg;

  // Operation codes, dense from zero. Codes past the last member are unused.
  typedef enum logic [5:0] {
    OP_ADD8     = 6'd0,
    OP_ADC8     = 6'd1,
    OP_SUB8     = 6'd2,
    OP_SBC8     = 6'd3,
    OP_CP8      = 6'd4,
    OP_AND8     = 6'd5,
    OP_OR8      = 6'd6,
    OP_XOR8     = 6'd7,
    OP_INC8     = 6'd8,
    OP_DEC8     = 6'd9,
    OP_RL       = 6'd10,
    OP_RLA      = 6'd11,
    OP_RLC      = 6'd12,
    OP_RLCA     = 6'd13,
    OP_RR       = 6'd14,
    OP_RRA      = 6'd15,
    OP_RRC      = 6'd16,
    OP_RRCA     = 6'd17,
    OP_SLA      = 6'd18,
    OP_SRA      = 6'd19,
    OP_SRL      = 6'd20,
    OP_SWAP     = 6'd21,
    OP_BIT      = 6'd22,
    OP_SET      = 6'd23,
    OP_RES      = 6'd24,
    OP_CPL      = 6'd25,
    OP_CCF      = 6'd26,
    OP_SCF      = 6'd27,
    OP_DAA      = 6'd28,
    OP_ADD16    = 6'd29,
    OP_ADC16    = 6'd30,
    OP_SBC16    = 6'd31,
    OP_INC16    = 6'd32,
    OP_DEC16    = 6'd33,
    OP_ADD16_SB = 6'd34
  } op_t;

  // Bit positions inside a four-bit flag nibble.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust correction values.
  localparam logic [7:0] DAA_ADJ_LO      = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI      = 8'h60;
  localparam logic [7:0] DAA_ADJ_BOTH    = 8'h66;
  localparam logic [7:0] DAA_SUB_BOTH    = 8'h9a;
  localparam logic [7:0] DAA_SUB_HI      = 8'ha0;
  localparam logic [7:0] DAA_SUB_LO      = 8'hfa;

  // Input word.
  typedef struct packed {
    logic [5:0]  op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [15:0] result;
    logic        writes_result;
    logic [3:0]  flags_out;
  } out_word_t;

endpackage

FILE: design/calu_core.sv
`timescale 1ns / 1ps

module calu_core (
  input  calu_pkg::in_word_t  word_i,
  output calu_pkg::out_word_t word_o
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        fz;
  logic        fn;
  logic        fh;
  logic        cin;
  logic        use_cin8;
  logic        use_cin16;
  logic [8:0]  sum8;
  logic [8:0]  diff8;
  logic [16:0] sum16;
  logic [16:0] diff16;
  logic [17:0] sum_sb;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [7:0]  daa_res;
  logic [15:0] res;
  logic        wr;
  logic [3:0]  nf;

  assign a8  = word_i.operand_a[7:0];
  assign b8  = word_i.operand_b[7:0];
  assign a16 = word_i.operand_a;
  assign b16 = word_i.operand_b;
  assign fz  = word_i.flags_in[calu_pkg::FLAG_Z];
  assign fn  = word_i.flags_in[calu_pkg::FLAG_N];
  assign fh  = word_i.flags_in[calu_pkg::FLAG_H];
  assign cin = word_i.flags_in[calu_pkg::FLAG_C];

  // In the adders, carry-in is used only by the with-carry forms.
  assign use_cin8  = ((calu_pkg::op_t'(word_i.op) == calu_pkg::OP_ADC8) ||
                      (calu_pkg::op_t'(word_i.op) == calu_pkg::OP_SBC8)) ? cin : 1'b0;
  assign use_cin16 = (calu_pkg::op_t'(word_i.op) == calu_pkg::OP_ADC16) ? cin : 1'b0;

  // Shared adders; the top bit is the carry or borrow out.
  assign sum8   = {1'b0, a8} + {1'b0, b8} + {8'd0, use_cin8};
  assign diff8  = {1'b0, a8} - {1'b0, b8} - {8'd0, use_cin8};
  assign sum16  = {1'b0, a16} + {1'b0, b16} + {16'd0, use_cin16};
  assign diff16 = {1'b0, a16} - {1'b0, b16} - {16'd0, cin};

  // Signed byte add: two guard bits catch both underflow and overflow.
  assign sum_sb = {2'b00, a16} + {{10{b8[7]}}, b8};

  assign bit_mask = 8'(8'd1 << word_i.bit_index);

  // Decimal adjust correction after an add or a subtract.
  always_comb begin
    daa_adj = 8'h00;
    daa_c   = 1'b0;
    if (fn) begin
      if (cin) begin
        daa_adj = fh ? calu_pkg::DAA_SUB_BOTH : calu_pkg::DAA_SUB_HI;
        daa_c   = 1'b1;
      end else if (fh) begin
        daa_adj = calu_pkg::DAA_SUB_LO;
      end
    end else if (cin) begin
      daa_adj = (fh || (a8[3:0] >= 4'ha)) ? calu_pkg::DAA_ADJ_BOTH : calu_pkg::DAA_ADJ_HI;
      daa_c   = 1'b1;
    end else if (fh) begin
      if (a8[7:4] >= 4'ha) begin
        daa_adj = calu_pkg::DAA_ADJ_BOTH;
        daa_c   = 1'b1;
      end else begin
        daa_adj = calu_pkg::DAA_ADJ_LO;
      end
    end else if (a8[3:0] >= 4'ha) begin
      if (a8[7:4] >= 4'h9) begin
        daa_adj = calu_pkg::DAA_ADJ_BOTH;
        daa_c   = 1'b1;
      end else begin
        daa_adj = calu_pkg::DAA_ADJ_LO;
      end
    end else if (a8[7:4] >= 4'ha) begin
      daa_adj = calu_pkg::DAA_ADJ_HI;
      daa_c   = 1'b1;
    end
  end

  assign daa_res = a8 + daa_adj;

  // Operation select. Flag nibble order is Z, N, H, C.
  always_comb begin
    res = 16'h0000;
    wr  = 1'b1;
    nf  = word_i.flags_in;
    case (calu_pkg::op_t'(word_i.op))
      calu_pkg::OP_ADD8, calu_pkg::OP_ADC8: begin
        res = {8'h00, sum8[7:0]};
        nf  = {sum8[7:0] == 8'h00, 1'b0, (a8[4] ^ b8[4] ^ sum8[4]), sum8[8]};
      end
      calu_pkg::OP_SUB8, calu_pkg::OP_SBC8, calu_pkg::OP_CP8: begin
        res = {8'h00, diff8[7:0]};
        nf  = {diff8[7:0] == 8'h00, 1'b1, (a8[4] ^ b8[4] ^ diff8[4]), diff8[8]};
        if (calu_pkg::op_t'(word_i.op) == calu_pkg::OP_CP8) begin
          wr = 1'b0;
        end
      end
      calu_pkg::OP_AND8: begin
        res = {8'h00, a8 & b8};
        nf  = {(a8 & b8) == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      calu_pkg::OP_OR8: begin
        res = {8'h00, a8 | b8};
        nf  = {(a8 | b8) == 8'h00, 3'b000};
      end
      calu_pkg::OP_XOR8: begin
        res = {8'h00, a8 ^ b8};
        nf  = {(a8 ^ b8) == 8'h00, 3'b000};
      end
      calu_pkg::OP_INC8: begin
        res = {8'h00, 8'(a8 + 8'd1)};
        nf  = {a8 == 8'hff, 1'b0, a8[3:0] == 4'hf, cin};
      end
      calu_pkg::OP_DEC8: begin
        res = {8'h00, 8'(a8 - 8'd1)};
        nf  = {a8 == 8'h01, 1'b1, a8[3:0] == 4'h0, cin};
      end
      calu_pkg::OP_RL: begin
        res = {8'h00, a8[6:0], cin};
        nf  = {{a8[6:0], cin} == 8'h00, 2'b00, a8[7]};
      end
      calu_pkg::OP_RLA: begin
        res = {8'h00, a8[6:0], cin};
        nf  = {fz, 2'b00, a8[7]};
      end
      calu_pkg::OP_RLC: begin
        res = {8'h00, a8[6:0], a8[7]};
        nf  = {a8 == 8'h00, 2'b00, a8[7]};
      end
      calu_pkg::OP_RLCA: begin
        res = {8'h00, a8[6:0], a8[7]};
        nf  = {fz, 2'b00, a8[7]};
      end
      calu_pkg::OP_RR: begin
        res = {8'h00, cin, a8[7:1]};
        nf  = {{cin, a8[7:1]} == 8'h00, 2'b00, a8[0]};
      end
      calu_pkg::OP_RRA: begin
        res = {8'h00, cin, a8[7:1]};
        nf  = {fz, 2'b00, a8[0]};
      end
      calu_pkg::OP_RRC: begin
        res = {8'h00, a8[0], a8[7:1]};
        nf  = {a8 == 8'h00, 2'b00, a8[0]};
      end
      calu_pkg::OP_RRCA: begin
        res = {8'h00, a8[0], a8[7:1]};
        nf  = {fz, 2'b00, a8[0]};
      end
      calu_pkg::OP_SLA: begin
        res = {8'h00, a8[6:0], 1'b0};
        nf  = {a8[6:0] == 7'h00, 2'b00, a8[7]};
      end
      calu_pkg::OP_SRA: begin
        res = {8'h00, a8[7], a8[7:1]};
        nf  = {a8[7:1] == 7'h00, 2'b00, a8[0]};
      end
      calu_pkg::OP_SRL: begin
        res = {8'h00, 1'b0, a8[7:1]};
        nf  = {a8[7:1] == 7'h00, 2'b00, a8[0]};
      end
      calu_pkg::OP_SWAP: begin
        res = {8'h00, a8[3:0], a8[7:4]};
        nf  = {a8 == 8'h00, 3'b000};
      end
      calu_pkg::OP_BIT: begin
        wr = 1'b0;
        nf = {(a8 & bit_mask) == 8'h00, 1'b0, 1'b1, cin};
      end
      calu_pkg::OP_SET: begin
        res = {8'h00, a8 | bit_mask};
      end
      calu_pkg::OP_RES: begin
        res = {8'h00, a8 & ~bit_mask};
      end
      calu_pkg::OP_CPL: begin
        res = {8'h00, ~a8};
        nf  = {fz, 1'b1, 1'b1, cin};
      end
      calu_pkg::OP_CCF: begin
        wr = 1'b0;
        nf = {fz, 1'b0, cin, ~cin};
      end
      calu_pkg::OP_SCF: begin
        wr = 1'b0;
        nf = {fz, 1'b0, 1'b0, 1'b1};
      end
      calu_pkg::OP_DAA: begin
        res = {8'h00, daa_res};
        nf  = {daa_res == 8'h00, fn, fh, daa_c};
      end
      calu_pkg::OP_ADD16: begin
        res = sum16[15:0];
        nf  = {fz, 1'b0, (a16[12] ^ b16[12] ^ sum16[12]), sum16[16]};
      end
      calu_pkg::OP_ADC16: begin
        res = sum16[15:0];
        nf  = {sum16[15:0] == 16'h0000, 1'b0, (a16[12] ^ b16[12] ^ sum16[12]), sum16[16]};
      end
      calu_pkg::OP_SBC16: begin
        res = diff16[15:0];
        nf  = {diff16[15:0] == 16'h0000, 1'b1, (a16[12] ^ b16[12] ^ diff16[12]),
               diff16[16]};
      end
      calu_pkg::OP_INC16: begin
        res = 16'(a16 + 16'd1);
      end
      calu_pkg::OP_DEC16: begin
        res = 16'(a16 - 16'd1);
      end
      calu_pkg::OP_ADD16_SB: begin
        res = sum_sb[15:0];
        nf  = {sum_sb[15:0] == 16'h0000, 1'b0, (a16[4] ^ b8[4] ^ sum_sb[4]),
               (sum_sb[17] | sum_sb[16])};
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  // A word that writes nothing carries a zero result.
  assign word_o.result        = wr ? res : 16'h0000;
  assign word_o.writes_result = wr;
  assign word_o.flags_out     = nf;

endmodule

FILE: design/cpu_alu_with_flags.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Word
// in_       input      in_valid / in_ready     calu_pkg::in_word_t
// out_      output     out_valid / out_ready   calu_pkg::out_word_t
//
// A word is registered on acceptance, evaluated by the ALU logic in the next
// cycle, and stored in the output register.
// One word is taken every cycle while the output side keeps up.
// Reset clears both valid bits; the word registers are not reset.
// When the output stalls, the input register still takes one more word if it is
// empty before in_ready drops.

module cpu_alu_with_flags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  calu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output calu_pkg::out_word_t out_word
);

  logic                in_valid_r;
  logic                in_valid_nxt;
  calu_pkg::in_word_t  in_word_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  calu_pkg::out_word_t out_word_r;
  calu_pkg::out_word_t alu_word;
  logic                out_load;
  logic                in_load;

  // The output register loads a held input word when empty or when its word is being taken.
  assign out_load = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || out_load;
  assign in_load  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Word registers.
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_word_r <= in_word;
    end
    if (out_load) begin
      out_word_r <= alu_word;
    end
  end

  calu_core u_core (
    .word_i (in_word_r),
    .word_o (alu_word)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: design/calu_checker.sv
`timescale 1ns / 1ps

module calu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input calu_pkg::out_word_t out_word
);

  logic [1:0] occ_r;
  logic [1:0] occ_nxt;

  // Words held inside the block.
  always_comb begin
    occ_nxt = occ_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      occ_nxt = 2'(occ_r + 2'd1);
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      occ_nxt = 2'(occ_r - 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 2'd0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // A pending result stays offered until taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn before it was taken");

  // No result appears without a word inside.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != 2'd0)
    else $error("result word offered with nothing in flight");

  // Never more than the two register stages hold, and the input is ready unless both are full.
  assert property (@(posedge clk) disable iff (!rst_n)
    occ_r != 2'd3 && (in_ready || occ_r == 2'd2))
    else $error("occupancy out of range or input stalled while not full");

  // Words that write nothing carry a zero result.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.writes_result |-> out_word.result == 16'h0000)
    else $error("non-writing word carries a nonzero result");

endmodule

bind cpu_alu_with_flags calu_checker u_calu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
